### sv/ict_pkg.sv
// Shared constants for the interval coalescing table.
// Holds command and status codes; no dependencies.
`default_nettype none
package ict_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [2:0] ST_COVERED   = 3'd0;
  localparam logic [2:0] ST_NEW       = 3'd1;
  localparam logic [2:0] ST_EXT_LOW   = 3'd2;
  localparam logic [2:0] ST_EXT_HIGH  = 3'd3;
  localparam logic [2:0] ST_JOINED    = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_READ_OK   = 3'd6;
  localparam logic [2:0] ST_BAD_INDEX = 3'd7;

endpackage
`default_nettype wire

### sv/interval_coalescing_table.sv
// Interval coalescing table: sorted disjoint ranges kept in one synchronous RAM.
// Reads return from the registered RAM port; a bad index skips the RAM read.
// One request at a time: in_ready is high only when idle, so no new item is taken before the last is done;
// the scan stops at the insert position and the shift moves only the entries past it.
// Reset clears the range count and control; the RAM itself is not cleared.
// Depends on ict_pkg.
`default_nettype none
module interval_coalescing_table
  import ict_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_value,
  input  wire logic [5:0]  in_entry_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_range_low,
  output logic [31:0]      out_range_high,
  output logic [6:0]       out_range_count
);

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int VW = VALUE_BITS;
  localparam int EW = CW + 6;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [VW-1:0] TOP = {VW{1'b1}};

  // Range RAM: low bound in the upper half, high bound in the lower half
  logic [2*VW-1:0] mem [MAX_INTERVALS];
  logic [2*VW-1:0] rdata_r;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  logic [2*VW-1:0] wd;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [VW-1:0]   v_r, v_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   chk_r, chk_nxt;
  logic            pend_r, pend_nxt;
  logic [2*VW-1:0] below_r, below_nxt;
  logic [2*VW-1:0] above_r, above_nxt;
  logic            hasb_r, hasb_nxt;
  logic            hasa_r, hasa_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            up_r, up_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   src_r, src_nxt;
  logic [CW-1:0]   psrc_r, psrc_nxt;
  logic [2:0]      res_st_r, res_st_nxt;
  logic [VW-1:0]   res_lo_r, res_lo_nxt;
  logic [VW-1:0]   res_hi_r, res_hi_nxt;

  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [31:0]     out_lo_r, out_hi_r;
  logic [6:0]      out_cnt_r;

  logic [VW+31:0]  v_ext;
  logic [EW-1:0]   idx_ext, cnt_ext;
  logic [VW-1:0]   lo_d, lo_b, hi_b, lo_a, hi_a;
  logic            covered, jb, ja;
  logic [VW+31:0]  rlo_ext, rhi_ext;
  logic [CW+6:0]   cnt_wide;

  assign v_ext   = {{VW{1'b0}}, in_value};
  assign idx_ext = EW'(in_entry_index);
  assign cnt_ext = EW'(cnt_r);
  assign lo_d    = rdata_r[2*VW-1:VW];
  assign lo_b    = below_r[2*VW-1:VW];
  assign hi_b    = below_r[VW-1:0];
  assign lo_a    = above_r[2*VW-1:VW];
  assign hi_a    = above_r[VW-1:0];
  assign covered = hasb_r && (hi_b >= v_r);
  assign jb      = hasb_r && (v_r != '0) && (hi_b == v_r - 1'b1);
  assign ja      = hasa_r && (v_r != TOP) && (lo_a == v_r + 1'b1);

  // RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  // Sequencer: serve reads, or scan for the insert position, then update and shift
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    v_nxt      = v_r;
    k_nxt      = k_r;
    chk_nxt    = chk_r;
    pend_nxt   = 1'b0;
    below_nxt  = below_r;
    above_nxt  = above_r;
    hasb_nxt   = hasb_r;
    hasa_nxt   = hasa_r;
    pos_nxt    = pos_r;
    up_nxt     = up_r;
    rem_nxt    = rem_r;
    src_nxt    = src_r;
    psrc_nxt   = psrc_r;
    res_st_nxt = res_st_r;
    res_lo_nxt = res_lo_r;
    res_hi_nxt = res_hi_r;
    rd_addr    = k_r[AW-1:0];
    we         = 1'b0;
    wa         = pos_r[AW-1:0];
    wd         = {v_r, v_r};
    in_ready   = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        rd_addr = idx_ext[AW-1:0];
        if (in_valid) begin
          v_nxt = v_ext[VW-1:0];
          if (in_cmd == CMD_READ) begin
            if (idx_ext < cnt_ext) begin
              state_nxt = S_RDWAIT;
            end else begin
              res_st_nxt = ST_BAD_INDEX;
              res_lo_nxt = '0;
              res_hi_nxt = '0;
              state_nxt  = S_FIN;
            end
          end else begin
            k_nxt     = '0;
            hasb_nxt  = 1'b0;
            hasa_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_RDWAIT: begin
        res_st_nxt = ST_READ_OK;
        res_lo_nxt = lo_d;
        res_hi_nxt = rdata_r[VW-1:0];
        state_nxt  = S_FIN;
      end
      S_SCAN: begin
        // issue the next read while checking the previous one
        if (k_r < cnt_r) begin
          pend_nxt = 1'b1;
          chk_nxt  = k_r[AW-1:0];
          k_nxt    = k_r + 1'b1;
        end
        if (pend_r) begin
          if (lo_d <= v_r) begin
            below_nxt = rdata_r;
            hasb_nxt  = 1'b1;
          end else begin
            above_nxt = rdata_r;
            hasa_nxt  = 1'b1;
            pos_nxt   = CW'(chk_r);
            state_nxt = S_DECIDE;
          end
        end else if (k_r >= cnt_r) begin
          pos_nxt   = cnt_r;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (covered) begin
          res_st_nxt = ST_COVERED;
          res_lo_nxt = lo_b;
          res_hi_nxt = hi_b;
          state_nxt  = S_FIN;
        end else if (jb && ja) begin
          we         = 1'b1;
          wa         = AW'(pos_r - 1'b1);
          wd         = {lo_b, hi_a};
          cnt_nxt    = cnt_r - 1'b1;
          res_st_nxt = ST_JOINED;
          res_lo_nxt = lo_b;
          res_hi_nxt = hi_a;
          up_nxt     = 1'b0;
          src_nxt    = pos_r + 1'b1;
          rem_nxt    = cnt_r - pos_r - 1'b1;
          state_nxt  = S_SHIFT;
        end else if (jb) begin
          we         = 1'b1;
          wa         = AW'(pos_r - 1'b1);
          wd         = {lo_b, v_r};
          res_st_nxt = ST_EXT_LOW;
          res_lo_nxt = lo_b;
          res_hi_nxt = v_r;
          state_nxt  = S_FIN;
        end else if (ja) begin
          we         = 1'b1;
          wd         = {v_r, hi_a};
          res_st_nxt = ST_EXT_HIGH;
          res_lo_nxt = v_r;
          res_hi_nxt = hi_a;
          state_nxt  = S_FIN;
        end else if (cnt_r >= CW'(MAX_INTERVALS)) begin
          res_st_nxt = ST_FULL;
          res_lo_nxt = v_r;
          res_hi_nxt = v_r;
          state_nxt  = S_FIN;
        end else begin
          cnt_nxt    = cnt_r + 1'b1;
          res_st_nxt = ST_NEW;
          res_lo_nxt = v_r;
          res_hi_nxt = v_r;
          up_nxt     = 1'b1;
          src_nxt    = cnt_r - 1'b1;
          rem_nxt    = cnt_r - pos_r;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // move one entry per cycle: read source, write it one slot over next cycle
        rd_addr = src_r[AW-1:0];
        if (rem_r != '0) begin
          pend_nxt = 1'b1;
          psrc_nxt = src_r;
          src_nxt  = up_r ? src_r - 1'b1 : src_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end
        if (pend_r) begin
          we = 1'b1;
          wa = up_r ? AW'(psrc_r + 1'b1) : AW'(psrc_r - 1'b1);
          wd = rdata_r;
        end else if (rem_r == '0) begin
          if (up_r) begin
            we = 1'b1;
            wd = {v_r, v_r};
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rlo_ext  = {32'b0, res_lo_r};
  assign rhi_ext  = {32'b0, res_hi_r};
  assign cnt_wide = (CW + 7)'(cnt_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    k_r      <= k_nxt;
    chk_r    <= chk_nxt;
    below_r  <= below_nxt;
    above_r  <= above_nxt;
    hasb_r   <= hasb_nxt;
    hasa_r   <= hasa_nxt;
    pos_r    <= pos_nxt;
    up_r     <= up_nxt;
    rem_r    <= rem_nxt;
    src_r    <= src_nxt;
    psrc_r   <= psrc_nxt;
    res_st_r <= res_st_nxt;
    res_lo_r <= res_lo_nxt;
    res_hi_r <= res_hi_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_status_r <= res_st_r;
      out_lo_r     <= rlo_ext[31:0];
      out_hi_r     <= rhi_ext[31:0];
      out_cnt_r    <= cnt_wide[6:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_range_low   = out_lo_r;
  assign out_range_high  = out_hi_r;
  assign out_range_count = out_cnt_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_INTERVALS))
    else $error("range count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1) ||
    (cnt_r == $past(cnt_r) - 1'b1))
    else $error("range count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !we)
    else $error("RAM write outside update");
`endif

endmodule
`default_nettype wire
